[src/bet_pkg.sv]
// Shared types, constants and helper functions for the binomial expansion block.
`default_nettype none

package bet_pkg;

  localparam int unsigned ExpW     = 6;
  localparam int unsigned CoefInW  = 16;
  localparam int unsigned PowW     = 8;
  localparam int unsigned ExpOutW  = 14;
  localparam int unsigned CoefOutW = 64;

  localparam logic [CoefOutW-1:0] CoefMin = 64'h8000_0000_0000_0000;
  localparam logic [CoefOutW-1:0] CoefMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [ExpW-1:0]           exponent;
    logic signed [CoefInW-1:0] coef_first;
    logic signed [CoefInW-1:0] coef_second;
    logic [PowW-1:0]           first_power;
    logic [PowW-1:0]           second_power;
  } bet_in_t;

  typedef struct packed {
    logic [ExpW-1:0]            term_index;
    logic signed [CoefOutW-1:0] term_coef;
    logic [ExpOutW-1:0]         first_exp_out;
    logic [ExpOutW-1:0]         second_exp_out;
    logic                       coef_is_zero;
    logic                       saturated;
    logic                       last_term;
  } bet_out_t;

  // Request to and response from the shared 64x64 multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] op_a;
    logic [63:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  // Inverses of the odd numbers 1..63 modulo 2^64, for exact division.
  typedef logic [63:0] inv_tab_t [32];

  function automatic inv_tab_t build_inv_tab();
    inv_tab_t    tab;
    logic [63:0] m;
    logic [63:0] x;
    for (int j = 0; j < 32; j++) begin
      m = 64'(2 * j + 1);
      x = m;
      for (int s = 0; s < 6; s++) begin
        x = x * (64'd2 - m * x);
      end
      tab[j] = x;
    end
    return tab;
  endfunction

  localparam inv_tab_t InvTab = build_inv_tab();

  // Count of trailing zero bits of a nonzero divisor.
  function automatic logic [2:0] trail_zeros(logic [ExpW-1:0] d);
    logic [2:0] z;
    z = '0;
    for (int k = ExpW - 1; k >= 0; k--) begin
      if (d[k]) begin
        z = 3'(k);
      end
    end
    return z;
  endfunction

endpackage

`default_nettype wire

[src/bet_mul.sv]
// Shared 64x64 multiplier built from one 32x32 multiplier over four partial products.
`default_nettype none

module bet_mul import bet_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [1:0] PartLoLo = 2'd0;
  localparam logic [1:0] PartLoHi = 2'd1;
  localparam logic [1:0] PartHiLo = 2'd2;
  localparam logic [2:0] StepEnd  = 3'd4;

  logic [63:0]  op_a_q, op_b_q;
  logic [63:0]  pp_q;
  logic [1:0]   pp_pos_q;
  logic         pp_vld_q;
  logic [127:0] acc_q;
  logic         busy_q;
  logic         done_q;
  logic [2:0]   step_q;

  logic [31:0]  x_sel, y_sel;
  logic [63:0]  pp_w;
  logic [127:0] pp_ext;

  always_comb begin
    case (step_q[1:0])
      PartLoLo: begin x_sel = op_a_q[31:0];  y_sel = op_b_q[31:0];  end
      PartLoHi: begin x_sel = op_a_q[31:0];  y_sel = op_b_q[63:32]; end
      PartHiLo: begin x_sel = op_a_q[63:32]; y_sel = op_b_q[31:0];  end
      default:  begin x_sel = op_a_q[63:32]; y_sel = op_b_q[63:32]; end
    endcase
  end

  assign pp_w = x_sel * y_sel;

  always_comb begin
    case (pp_pos_q) inside
      PartLoLo:           pp_ext = {64'b0, pp_q};
      PartLoHi, PartHiLo: pp_ext = {32'b0, pp_q, 32'b0};
      default:            pp_ext = {pp_q, 64'b0};
    endcase
  end

  // Sequence control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
      pp_vld_q <= 1'b0;
    end else begin
      done_q <= busy_q && !req_i.start && (step_q == StepEnd);
      if (req_i.start) begin
        busy_q   <= 1'b1;
        step_q   <= '0;
        pp_vld_q <= 1'b0;
      end else if (busy_q) begin
        if (step_q != StepEnd) begin
          pp_vld_q <= 1'b1;
          step_q   <= step_q + 3'd1;
        end else begin
          pp_vld_q <= 1'b0;
          busy_q   <= 1'b0;
        end
      end
    end
  end

  // Operands, partial product and accumulator.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_a_q <= req_i.op_a;
      op_b_q <= req_i.op_b;
      acc_q  <= '0;
    end else begin
      if (busy_q && step_q != StepEnd) begin
        pp_q     <= pp_w;
        pp_pos_q <= step_q[1:0];
      end
      if (pp_vld_q) begin
        acc_q <= acc_q + pp_ext;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

[src/binomial_expansion_terms.sv]
// Top level: expands (a*x^p + b*y^q)^n into its n+1 terms, one result per term.
`default_nettype none

// Takes one binomial per input transfer and returns its n+1 terms in order of
// rising index, then takes the next binomial. The exponent is clamped to
// MAX_EXPONENT and only the low COEF_WIDTH bits of each coefficient count, as
// a signed value. All products run on one 32x32 multiplier, one 64-bit
// product at a time: one product for each power of a, two to form each
// term, three more between terms (exact binomial update and the power of b).
// The last term is held in the output register while the next binomial is
// already accepted.
module binomial_expansion_terms import bet_pkg::*; #(
  parameter int unsigned MAX_EXPONENT = 63,
  parameter int unsigned COEF_WIDTH   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bet_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bet_out_t out_data_o
);

  localparam int unsigned     AddrW = $clog2(MAX_EXPONENT + 1);
  localparam logic [ExpW-1:0] MaxN  = ExpW'(MAX_EXPONENT);

  typedef enum logic [3:0] {
    S_IDLE, S_PWA, S_PWA_W, S_RD, S_T1, S_T1_W, S_T2, S_T2_W,
    S_EMIT, S_C1, S_C1_W, S_C2, S_C2_W, S_B, S_B_W
  } state_e;

  state_e                  state_q;
  logic [ExpW-1:0]         n_q, k_q, i_q;
  logic [COEF_WIDTH-1:0]   mag_a_q, mag_b_q;
  logic                    neg_a_q, neg_b_q;
  logic [PowW-1:0]         p_q, q_q;
  logic [63:0]             prev_q, binom_q, powb_q, work_q;
  logic                    out_valid_q;
  bet_out_t                out_q;

  logic [63:0]             pow_mem [MAX_EXPONENT+1];
  logic [63:0]             pow_rd_q;
  logic                    mem_we;
  logic [AddrW-1:0]        mem_waddr;
  logic [63:0]             mem_wdata;

  mul_req_t                mul_req;
  mul_rsp_t                mul_rsp;

  logic [ExpW-1:0]         n_w, r_w, d_w, odd_w;
  logic [2:0]              tz_w;
  logic [4:0]              inv_idx_w;
  logic [63:0]             prod_sat_w, quo_w;
  logic [31:0]             raw_a_w, raw_b_w;
  logic [COEF_WIDTH-1:0]   va_w, vb_w, mag_a_w, mag_b_w;
  logic                    neg_w, zero_w, sat_w;
  logic [CoefOutW-1:0]     coef_w;
  logic [ExpOutW-1:0]      fexp_w, sexp_w;
  logic                    in_xfer;

  bet_mul u_bet_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Input decode: clamp exponent, take the low COEF_WIDTH bits as a signed value.
  assign n_w     = (in_data_i.exponent > MaxN) ? MaxN : in_data_i.exponent;
  assign raw_a_w = {{(32 - CoefInW){1'b0}}, in_data_i.coef_first};
  assign raw_b_w = {{(32 - CoefInW){1'b0}}, in_data_i.coef_second};
  assign va_w    = raw_a_w[COEF_WIDTH-1:0];
  assign vb_w    = raw_b_w[COEF_WIDTH-1:0];
  assign mag_a_w = va_w[COEF_WIDTH-1] ? (~va_w + 1'b1) : va_w;
  assign mag_b_w = vb_w[COEF_WIDTH-1] ? (~vb_w + 1'b1) : vb_w;

  assign r_w        = n_q - i_q;
  assign d_w        = i_q + 6'd1;
  assign tz_w       = trail_zeros(d_w);
  assign odd_w      = d_w >> tz_w;
  assign inv_idx_w  = odd_w[5:1];
  assign prod_sat_w = (|mul_rsp.prod[127:64]) ? '1 : mul_rsp.prod[63:0];
  // C(n,i)*(n-i) is an exact multiple of i+1: drop the power of two,
  // then multiply by the odd part's inverse.
  assign quo_w      = 64'(mul_rsp.prod >> tz_w);

  // Shared multiplier operand selection.
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.op_a  = prev_q;
    mul_req.op_b  = 64'(mag_a_q);
    unique case (state_q)
      S_PWA: begin
        mul_req.start = 1'b1;
      end
      S_T1: begin
        mul_req.start = 1'b1;
        mul_req.op_a  = binom_q;
        mul_req.op_b  = pow_rd_q;
      end
      S_T2: begin
        mul_req.start = 1'b1;
        mul_req.op_a  = work_q;
        mul_req.op_b  = powb_q;
      end
      S_C1: begin
        mul_req.start = 1'b1;
        mul_req.op_a  = binom_q;
        mul_req.op_b  = 64'(r_w);
      end
      S_C2: begin
        mul_req.start = 1'b1;
        mul_req.op_a  = work_q;
        mul_req.op_b  = InvTab[inv_idx_w];
      end
      S_B: begin
        mul_req.start = 1'b1;
        mul_req.op_a  = powb_q;
        mul_req.op_b  = 64'(mag_b_q);
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  // Power table writes: a^0 on accept, then one entry per product.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = 64'd1;
    if (in_xfer) begin
      mem_we = 1'b1;
    end else if (state_q == S_PWA_W && mul_rsp.done) begin
      mem_we    = 1'b1;
      mem_waddr = k_q[AddrW-1:0];
      mem_wdata = prod_sat_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pow_mem[mem_waddr] <= mem_wdata;
    end
    pow_rd_q <= pow_mem[r_w[AddrW-1:0]];
  end

  // Signed, saturated coefficient of the current term.
  always_comb begin
    neg_w  = (neg_a_q & r_w[0]) ^ (neg_b_q & i_q[0]);
    zero_w = (work_q == 64'd0);
    sat_w  = 1'b0;
    coef_w = work_q;
    if (zero_w) begin
      coef_w = '0;
    end else if (neg_w) begin
      if (work_q > CoefMin) begin
        sat_w  = 1'b1;
        coef_w = CoefMin;
      end else begin
        coef_w = ~work_q + 64'd1;
      end
    end else if (work_q > CoefMax) begin
      sat_w  = 1'b1;
      coef_w = CoefMax;
    end
  end

  assign fexp_w = {{(ExpOutW - PowW){1'b0}}, p_q} * {{(ExpOutW - ExpW){1'b0}}, r_w};
  assign sexp_w = {{(ExpOutW - PowW){1'b0}}, q_q} * {{(ExpOutW - ExpW){1'b0}}, i_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      mag_a_q     <= '0;
      mag_b_q     <= '0;
      neg_a_q     <= 1'b0;
      neg_b_q     <= 1'b0;
      p_q         <= '0;
      q_q         <= '0;
      prev_q      <= '0;
      binom_q     <= '0;
      powb_q      <= '0;
      work_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the output once transferred, unless a new term replaces it.
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            n_q     <= n_w;
            mag_a_q <= mag_a_w;
            mag_b_q <= mag_b_w;
            neg_a_q <= va_w[COEF_WIDTH-1];
            neg_b_q <= vb_w[COEF_WIDTH-1];
            p_q     <= in_data_i.first_power;
            q_q     <= in_data_i.second_power;
            prev_q  <= 64'd1;
            k_q     <= 6'd1;
            if (n_w == '0) begin
              i_q     <= '0;
              binom_q <= 64'd1;
              powb_q  <= 64'd1;
              state_q <= S_RD;
            end else begin
              state_q <= S_PWA;
            end
          end
        end
        S_PWA: state_q <= S_PWA_W;
        S_PWA_W: begin
          if (mul_rsp.done) begin
            prev_q <= prod_sat_w;
            if (k_q == n_q) begin
              i_q     <= '0;
              binom_q <= 64'd1;
              powb_q  <= 64'd1;
              state_q <= S_RD;
            end else begin
              k_q     <= k_q + 6'd1;
              state_q <= S_PWA;
            end
          end
        end
        // Let the table read of a^(n-i) land.
        S_RD: state_q <= S_T1;
        S_T1: state_q <= S_T1_W;
        S_T1_W: begin
          if (mul_rsp.done) begin
            work_q  <= prod_sat_w;
            state_q <= S_T2;
          end
        end
        S_T2: state_q <= S_T2_W;
        S_T2_W: begin
          if (mul_rsp.done) begin
            work_q  <= prod_sat_w;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_q.term_index     <= i_q;
            out_q.term_coef      <= coef_w;
            out_q.first_exp_out  <= fexp_w;
            out_q.second_exp_out <= sexp_w;
            out_q.coef_is_zero   <= zero_w;
            out_q.saturated      <= sat_w;
            out_q.last_term      <= (i_q == n_q);
            if (i_q == n_q) begin
              i_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_C1;
            end
          end
        end
        S_C1: state_q <= S_C1_W;
        S_C1_W: begin
          if (mul_rsp.done) begin
            work_q  <= quo_w;
            state_q <= S_C2;
          end
        end
        S_C2: state_q <= S_C2_W;
        S_C2_W: begin
          if (mul_rsp.done) begin
            binom_q <= mul_rsp.prod[63:0];
            state_q <= S_B;
          end
        end
        S_B: state_q <= S_B_W;
        S_B_W: begin
          if (mul_rsp.done) begin
            powb_q  <= prod_sat_w;
            i_q     <= i_q + 6'd1;
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[src/bet_checker.sv]
// Port-level checker for the binomial expansion block, with its bind.
`default_nettype none

module bet_checker import bet_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input bet_out_t out_data_i
);

  logic            pending_q;
  logic [ExpW-1:0] exp_idx_q;
  logic            in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Track the item in flight and the index of the next term.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      exp_idx_q <= '0;
    end else begin
      if (in_xfer) begin
        pending_q <= 1'b1;
      end else if (out_xfer && out_data_i.last_term) begin
        pending_q <= 1'b0;
      end
      if (out_xfer) begin
        exp_idx_q <= out_data_i.last_term ? '0 : out_data_i.term_index + 6'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped before transfer");

  a_term_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.term_index == exp_idx_q)
    else $error("term index out of order");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q && !(out_valid_i && out_data_i.last_term) |-> !in_ready_i)
    else $error("input taken while terms of the previous item remain");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.saturated |->
      !out_data_i.coef_is_zero &&
      (out_data_i.term_coef == CoefMax || out_data_i.term_coef == CoefMin))
    else $error("saturated term without a limit coefficient");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.coef_is_zero |-> out_data_i.term_coef == '0)
    else $error("zero flag with nonzero coefficient");

endmodule

bind binomial_expansion_terms bet_checker u_bet_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

[dv/tb_binomial_expansion_terms.sv]
// Self-checking testbench for the binomial expansion block: directed and random binomials.
`timescale 1ns / 1ps

module tb_binomial_expansion_terms import bet_pkg::*;;

  localparam int unsigned MaxExponent = 63;
  localparam int unsigned CoefWidth   = 16;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned QuietLimit  = 8000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned RandomCount = 268;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  bet_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  bet_out_t out_data_o;

  bet_out_t    pending_terms[$];
  int unsigned error_count;
  int unsigned binomials_sent;
  int unsigned terms_checked;
  int unsigned saturated_seen;
  int unsigned zero_seen;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_request;
  bit          steady;

  binomial_expansion_terms #(
    .MAX_EXPONENT(MaxExponent),
    .COEF_WIDTH  (CoefWidth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Unsigned product, pinned at all ones when it does not fit in 64 bits.
  function automatic logic [63:0] capped_mul(logic [63:0] x, logic [63:0] y);
    logic [127:0] full;
    full = {64'd0, x} * {64'd0, y};
    return (full[127:64] != '0) ? '1 : full[63:0];
  endfunction

  // Queue the n+1 terms of one binomial.
  task automatic expand_binomial(input bet_in_t item);
    int unsigned  n;
    int unsigned  r;
    logic [63:0]  pow_a [64];
    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [63:0]  choose;
    logic [63:0]  pow_b;
    logic [63:0]  mag;
    logic [127:0] wide;
    logic         neg_a;
    logic         neg_b;
    logic         neg;
    bet_out_t     t;
    n = item.exponent;
    if (n > MaxExponent) n = MaxExponent;
    neg_a = item.coef_first[CoefInW-1];
    neg_b = item.coef_second[CoefInW-1];
    mag_a = neg_a ? (64'd1 << CoefInW) - {48'd0, item.coef_first} : {48'd0, item.coef_first};
    mag_b = neg_b ? (64'd1 << CoefInW) - {48'd0, item.coef_second}
                  : {48'd0, item.coef_second};
    pow_a[0] = 64'd1;
    for (int unsigned k = 1; k <= n; k++) pow_a[k] = capped_mul(pow_a[k-1], mag_a);
    choose = 64'd1;
    pow_b  = 64'd1;
    for (int unsigned i = 0; i <= n; i++) begin
      r   = n - i;
      mag = capped_mul(capped_mul(choose, pow_a[r]), pow_b);
      neg = (neg_a && (r % 2 == 1)) != (neg_b && (i % 2 == 1));
      t.term_index   = ExpW'(i);
      t.coef_is_zero = (mag == '0);
      t.saturated    = 1'b0;
      if (mag == '0) begin
        t.term_coef = '0;
      end else if (neg) begin
        if (mag > CoefMin) begin
          t.saturated = 1'b1;
          mag = CoefMin;
        end
        t.term_coef = 64'd0 - mag;
      end else begin
        if (mag > CoefMax) begin
          t.saturated = 1'b1;
          mag = CoefMax;
        end
        t.term_coef = mag;
      end
      t.first_exp_out  = ExpOutW'(item.first_power * r);
      t.second_exp_out = ExpOutW'(item.second_power * i);
      t.last_term      = (i == n);
      pending_terms.push_back(t);
      if (i < n) begin
        // exact: C(n,i)*(n-i) is always divisible by i+1
        wide   = {64'd0, choose} * (n - i);
        choose = 64'(wide / (i + 1));
        pow_b  = capped_mul(pow_b, mag_b);
      end
    end
  endtask

  function automatic bet_in_t make_binomial(int unsigned n, int a, int b,
                                            int unsigned p, int unsigned q);
    bet_in_t item;
    item.exponent     = ExpW'(n);
    item.coef_first   = CoefInW'(a);
    item.coef_second  = CoefInW'(b);
    item.first_power  = PowW'(p);
    item.second_power = PowW'(q);
    return item;
  endfunction

  function automatic logic [CoefInW-1:0] random_coef();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return CoefInW'($urandom_range(8) - 4);
    if (pick < 55) begin
      case ($urandom_range(3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return CoefInW'($urandom);
  endfunction

  // Mostly short expansions; a few long ones and the full length now and then.
  function automatic bet_in_t random_binomial();
    bet_in_t     item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3)       item.exponent = ExpW'(MaxExponent);
    else if (pick < 15) item.exponent = ExpW'($urandom_range(62, 11));
    else                item.exponent = ExpW'($urandom_range(10));
    item.coef_first   = random_coef();
    item.coef_second  = random_coef();
    item.first_power  = PowW'($urandom);
    item.second_power = PowW'($urandom);
    return item;
  endfunction

  // Offer one binomial and hold it until the transfer; valid stays high afterward.
  task automatic offer_binomial(input bet_in_t item);
    if (!steady && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 16);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expand_binomial(item);
    binomials_sent++;
  endtask

  initial begin : receiver
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk_i) begin : check_terms
    bet_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_terms.size() == 0) begin
        $error("unexpected term, index %0d", out_data_o.term_index);
        error_count++;
      end else begin
        want = pending_terms.pop_front();
        terms_checked++;
        if (out_data_o.saturated) saturated_seen++;
        if (out_data_o.coef_is_zero) zero_seen++;
        if (out_data_o.term_index !== want.term_index) begin
          $error("term_index: expected %0d, got %0d", want.term_index, out_data_o.term_index);
          error_count++;
        end
        if (out_data_o.term_coef !== want.term_coef) begin
          $error("term_coef: expected %0d, got %0d", want.term_coef, out_data_o.term_coef);
          error_count++;
        end
        if (out_data_o.first_exp_out !== want.first_exp_out) begin
          $error("first_exp_out: expected %0d, got %0d",
                 want.first_exp_out, out_data_o.first_exp_out);
          error_count++;
        end
        if (out_data_o.second_exp_out !== want.second_exp_out) begin
          $error("second_exp_out: expected %0d, got %0d",
                 want.second_exp_out, out_data_o.second_exp_out);
          error_count++;
        end
        if (out_data_o.coef_is_zero !== want.coef_is_zero) begin
          $error("coef_is_zero: expected %0d, got %0d",
                 want.coef_is_zero, out_data_o.coef_is_zero);
          error_count++;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, out_data_o.saturated);
          error_count++;
        end
        if (out_data_o.last_term !== want.last_term) begin
          $error("last_term: expected %0d, got %0d", want.last_term, out_data_o.last_term);
          error_count++;
        end
      end
    end
  end

  // End the run if neither channel moves a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_zero_power();
    offer_binomial(make_binomial(0, 0, 0, 0, 0));
    offer_binomial(make_binomial(0, -32768, 32767, 255, 255));
    offer_binomial(make_binomial(4, 0, 0, 9, 3));
  endtask

  task automatic test_range_extremes();
    offer_binomial(make_binomial(63, 1, 1, 255, 255));
    // a = -2: first term is exactly the most negative value, the terms right after it overflow
    offer_binomial(make_binomial(63, -2, 1, 1, 2));
    offer_binomial(make_binomial(63, 2, -1, 2, 1));
    offer_binomial(make_binomial(63, -32768, -32768, 255, 0));
    offer_binomial(make_binomial(1, 32767, -32768, 0, 0));
    offer_binomial(make_binomial(62, -1, -1, 128, 127));
  endtask

  task automatic test_zero_terms();
    offer_binomial(make_binomial(5, 0, 7, 11, 13));
    offer_binomial(make_binomial(5, 3, 0, 13, 11));
  endtask

  task automatic test_bit_patterns();
    offer_binomial(make_binomial(31, 7, -3, 170, 85));
    offer_binomial(make_binomial(42, 21845, -21846, 85, 170));
    offer_binomial(make_binomial(21, -21846, 21845, 170, 85));
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (40) offer_binomial(random_binomial());
    steady = 1'b0;
  endtask

  // Stall the output long enough that the block backs up into its input.
  task automatic test_output_hold();
    steady       = 1'b1;
    hold_request = 1'b1;
    repeat (8) offer_binomial(make_binomial($urandom_range(4, 1), $urandom, $urandom,
                                            $urandom, $urandom));
    steady = 1'b0;
  endtask

  task automatic test_random_mix();
    repeat (RandomCount) offer_binomial(random_binomial());
  endtask

  initial begin
    error_count    = 0;
    binomials_sent = 0;
    terms_checked  = 0;
    saturated_seen = 0;
    zero_seen      = 0;
    hold_left      = 0;
    hold_request   = 1'b0;
    steady         = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_power();
    test_range_extremes();
    test_zero_terms();
    test_bit_patterns();
    test_steady_stream();
    test_output_hold();
    test_random_mix();

    in_valid_i <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Expanded %0d binomials into %0d checked terms (%0d saturated, %0d zero).",
             binomials_sent, terms_checked, saturated_seen, zero_seen);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
